// ===== hw/rtl/dtffv_pkg.sv =====
`timescale 1ns / 1ps
// Package for the drivetrain feedforward voltage block: transaction types,
// register indexes and reset values, and the fixed-point helpers.
// No dependencies.
package dtffv_pkg;

	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_HALF_TRACK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_RADIUS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR_TORQUE_GAIN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_TORQUE_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DRAG_TORQUE_GAIN = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_GEAR_MOTOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_GEAR_MOTOR = 3'd6;

	localparam logic [30:0] RST_HALF_TRACK = 31'd19661;
	localparam logic [30:0] RST_INV_WHEEL_RADIUS = 31'd1310720;
	localparam logic [30:0] RST_LINEAR_TORQUE_GAIN = 31'd98304;
	localparam logic [30:0] RST_ANGULAR_TORQUE_GAIN = 31'd27307;
	localparam logic [30:0] RST_DRAG_TORQUE_GAIN = 31'd65536;
	localparam logic [63:0] RST_GEAR_MOTOR = 64'd0;

	localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
	localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] linear_velocity;
		logic signed [31:0] angular_velocity;
		logic signed [31:0] linear_accel;
		logic signed [31:0] angular_accel;
		logic               gear_high;
	} req_t;

	typedef struct packed {
		logic signed [31:0] left_voltage;
		logic signed [31:0] right_voltage;
		logic               saturated;
	} rsp_t;

	typedef struct packed {
		logic [30:0] half_track;
		logic [30:0] inv_wheel_radius;
		logic [30:0] linear_torque_gain;
		logic [30:0] angular_torque_gain;
		logic [30:0] drag_torque_gain;
		logic [63:0] low_gear_motor;
		logic [63:0] high_gear_motor;
	} cfg_t;

	// per-wheel work handed from the front end to a wheel pipe
	typedef struct packed {
		logic signed [31:0] wheel_sum;
		logic signed [31:0] torque;
		logic [23:0]        inv_torque_gain;
		logic [23:0]        inv_speed_gain;
		logic [15:0]        friction;
		logic               ovf;
	} wheel_in_t;

	typedef struct packed {
		logic signed [31:0] voltage;
		logic               ovf;
	} wheel_out_t;

	function automatic logic signed [63:0] mul32(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [63:0] p;
		p = 64'(a) * 64'(b);
		return p;
	endfunction

	// floor((p + 2^15) / 2^16)
	function automatic logic signed [47:0] rnd16(input logic signed [63:0] p);
		logic signed [63:0] y;
		y = p + 64'sd32768;
		return $signed(y[63:16]);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > S32_MAX) begin
			r = 32'sh7fffffff;
		end else if (x < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = $signed(x[31:0]);
		end
		return r;
	endfunction

	function automatic logic ovf32(input logic signed [63:0] x);
		return (x > S32_MAX) || (x < S32_MIN);
	endfunction

endpackage

// ===== hw/rtl/dtffv_cfg.sv =====
`timescale 1ns / 1ps
// Configuration register file for the drivetrain feedforward voltage block.
// Depends on dtffv_pkg.
module dtffv_cfg
	import dtffv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_track <= RST_HALF_TRACK;
			cfg_q.inv_wheel_radius <= RST_INV_WHEEL_RADIUS;
			cfg_q.linear_torque_gain <= RST_LINEAR_TORQUE_GAIN;
			cfg_q.angular_torque_gain <= RST_ANGULAR_TORQUE_GAIN;
			cfg_q.drag_torque_gain <= RST_DRAG_TORQUE_GAIN;
			cfg_q.low_gear_motor <= RST_GEAR_MOTOR;
			cfg_q.high_gear_motor <= RST_GEAR_MOTOR;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HALF_TRACK: cfg_q.half_track <= cfg_data[30:0];
				REG_INV_WHEEL_RADIUS: cfg_q.inv_wheel_radius <= cfg_data[30:0];
				REG_LINEAR_TORQUE_GAIN: cfg_q.linear_torque_gain <= cfg_data[30:0];
				REG_ANGULAR_TORQUE_GAIN: cfg_q.angular_torque_gain <= cfg_data[30:0];
				REG_DRAG_TORQUE_GAIN: cfg_q.drag_torque_gain <= cfg_data[30:0];
				REG_LOW_GEAR_MOTOR: cfg_q.low_gear_motor <= cfg_data;
				REG_HIGH_GEAR_MOTOR: cfg_q.high_gear_motor <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== hw/rtl/dtffv_front.sv =====
`timescale 1ns / 1ps
// Front end, stages 1 and 2: chassis products, wheel sums and wheel torques.
// Depends on dtffv_pkg.
module dtffv_front
	import dtffv_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  req_t      req,
	input  cfg_t      cfg,
	output logic      valid,
	output wheel_in_t left,
	output wheel_in_t right
);

	logic               valid_s1;
	logic signed [31:0] vl_s1;
	logic signed [47:0] pb_s1;
	logic signed [47:0] pl_s1;
	logic signed [47:0] pa_s1;
	logic signed [47:0] pd_s1;
	logic [63:0]        motor_s1;

	logic               valid_s2;
	wheel_in_t          left_s2;
	wheel_in_t          right_s2;

	logic signed [63:0] sum_l;
	logic signed [63:0] sum_r;
	logic signed [63:0] trq_l;
	logic signed [63:0] trq_r;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	// stage 1: chassis products, motor word select
	always_ff @(posedge clk) begin
		vl_s1 <= req.linear_velocity;
		pb_s1 <= rnd16(mul32(req.angular_velocity, $signed({1'b0, cfg.half_track})));
		pl_s1 <= rnd16(mul32(req.linear_accel, $signed({1'b0, cfg.linear_torque_gain})));
		pa_s1 <= rnd16(mul32(req.angular_accel, $signed({1'b0, cfg.angular_torque_gain})));
		pd_s1 <= rnd16(mul32(req.angular_velocity, $signed({1'b0, cfg.drag_torque_gain})));
		motor_s1 <= req.gear_high ? cfg.high_gear_motor : cfg.low_gear_motor;
	end

	always_comb begin
		sum_l = 64'(vl_s1) - 64'(pb_s1);
		sum_r = 64'(vl_s1) + 64'(pb_s1);
		trq_l = 64'(pl_s1) - 64'(pa_s1) - 64'(pd_s1);
		trq_r = 64'(pl_s1) + 64'(pa_s1) + 64'(pd_s1);
	end

	// stage 2: wheel sums and torques, saturated
	always_ff @(posedge clk) begin
		left_s2.wheel_sum <= sat32(sum_l);
		left_s2.torque <= sat32(trq_l);
		left_s2.inv_torque_gain <= motor_s1[63:40];
		left_s2.inv_speed_gain <= motor_s1[39:16];
		left_s2.friction <= motor_s1[15:0];
		left_s2.ovf <= ovf32(sum_l) | ovf32(trq_l);
		right_s2.wheel_sum <= sat32(sum_r);
		right_s2.torque <= sat32(trq_r);
		right_s2.inv_torque_gain <= motor_s1[63:40];
		right_s2.inv_speed_gain <= motor_s1[39:16];
		right_s2.friction <= motor_s1[15:0];
		right_s2.ovf <= ovf32(sum_r) | ovf32(trq_r);
	end

	assign valid = valid_s2;
	assign left = left_s2;
	assign right = right_s2;

endmodule

// ===== hw/rtl/dtffv_wheel.sv =====
`timescale 1ns / 1ps
// Wheel pipe, stages 3 to 6: wheel speed, torque and speed terms, friction,
// final voltage with saturation. Depends on dtffv_pkg.
module dtffv_wheel
	import dtffv_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  wheel_in_t  wheel,
	input  logic [30:0] inv_wheel_radius,
	output logic       valid,
	output wheel_out_t result
);

	logic               valid_s3;
	logic signed [63:0] ws_s3;
	logic signed [56:0] tp_s3;
	logic signed [31:0] t_s3;
	logic [23:0]        isg_s3;
	logic [15:0]        fr_s3;
	logic               ovf_s3;

	logic               valid_s4;
	logic signed [31:0] w_s4;
	logic signed [40:0] tv_s4;
	logic signed [31:0] t_s4;
	logic [23:0]        isg_s4;
	logic [15:0]        fr_s4;
	logic               ovf_s4;

	logic               valid_s5;
	logic signed [56:0] wp_s5;
	logic signed [40:0] tv_s5;
	logic signed [24:0] fv_s5;
	logic               zero_s5;
	logic               ovf_s5;

	logic               valid_s6;
	logic signed [31:0] voltage_s6;
	logic               ovf_s6;

	logic signed [47:0] w_rnd;
	logic signed [24:0] fr_pos;
	logic signed [63:0] v_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			valid_s3 <= in_valid;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
			valid_s6 <= valid_s5;
		end
	end

	// stage 3: wheel speed product and torque term product
	always_ff @(posedge clk) begin
		ws_s3 <= mul32(wheel.wheel_sum, $signed({1'b0, inv_wheel_radius}));
		tp_s3 <= 57'(mul32(wheel.torque, $signed({8'h00, wheel.inv_torque_gain})));
		t_s3 <= wheel.torque;
		isg_s3 <= wheel.inv_speed_gain;
		fr_s3 <= wheel.friction;
		ovf_s3 <= wheel.ovf;
	end

	assign w_rnd = rnd16(ws_s3);

	// stage 4: round and clip the wheel speed, round the torque term
	always_ff @(posedge clk) begin
		w_s4 <= sat32(64'(w_rnd));
		tv_s4 <= 41'(rnd16(64'(tp_s3)));
		t_s4 <= t_s3;
		isg_s4 <= isg_s3;
		fr_s4 <= fr_s3;
		ovf_s4 <= ovf_s3 | ovf32(64'(w_rnd));
	end

	assign fr_pos = $signed({1'b0, fr_s4, 8'h00});

	// stage 5: speed term product, friction sign from speed, else torque
	always_ff @(posedge clk) begin
		wp_s5 <= 57'(mul32(w_s4, $signed({8'h00, isg_s4})));
		tv_s5 <= tv_s4;
		ovf_s5 <= ovf_s4;
		zero_s5 <= (w_s4 == 32'sd0) && (t_s4 == 32'sd0);
		if (w_s4 > 32'sd0) begin
			fv_s5 <= fr_pos;
		end else if (w_s4 < 32'sd0) begin
			fv_s5 <= -fr_pos;
		end else if (t_s4 > 32'sd0) begin
			fv_s5 <= fr_pos;
		end else begin
			fv_s5 <= -fr_pos;
		end
	end

	assign v_sum = 64'(rnd16(64'(wp_s5))) + 64'(tv_s5) + 64'(fv_s5);

	// stage 6: sum terms with saturation, drop to zero for a still and unloaded wheel
	always_ff @(posedge clk) begin
		if (zero_s5) begin
			voltage_s6 <= 32'sd0;
			ovf_s6 <= ovf_s5;
		end else begin
			voltage_s6 <= sat32(v_sum);
			ovf_s6 <= ovf_s5 | ovf32(v_sum);
		end
	end

	assign valid = valid_s6;
	assign result.voltage = voltage_s6;
	assign result.ovf = ovf_s6;

	a_valid_chain: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s6 |-> $past(valid_s3, 3))
		else $error("wheel pipe valid out of step");

	a_zero_voltage: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && zero_s5) |=> (voltage_s6 == 32'sd0))
		else $error("still unloaded wheel gave nonzero voltage");

	a_ovf_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s5 && ovf_s5) |=> ovf_s6)
		else $error("saturation flag lost in final stage");

endmodule

// ===== hw/rtl/drivetrain_feedforward_voltage.sv =====
`timescale 1ns / 1ps
// Top level of the drivetrain feedforward voltage block.
// Depends on dtffv_pkg, dtffv_cfg, dtffv_front and dtffv_wheel.
//
// Usage:
//  A transaction is taken at each rising edge with start high and busy low.
//  busy is always low: a new transaction may be started in every cycle.
//  req carries chassis linear/angular velocity and acceleration (Q16.16)
//  and the gear select. The voltages appear on result for exactly one cycle,
//  marked by done; results come in order. Throughput is one transaction
//  per cycle, through two front stages (chassis products, sums and
//  torques) and four wheel stages (speed product, rounding, speed-term
//  product, final sum), at most one 32x32 multiplier level per stage,
//  both wheels in parallel.
//  The receiver cannot stall; done is a strobe and must be taken.
//  Registers are written through cfg_we, cfg_index and cfg_data, one per
//  cycle, by the user only while no transaction is in flight (unenforced).
//  Reset clears the pipeline and loads the register defaults.
module drivetrain_feedforward_voltage
	import dtffv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output rsp_t                  result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t       cfg;
	logic       front_valid;
	wheel_in_t  left_in;
	wheel_in_t  right_in;
	logic       left_valid;
	logic       right_valid;
	wheel_out_t left_out;
	wheel_out_t right_out;

	assign busy = 1'b0;

	dtffv_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	dtffv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (start & ~busy),
		.req      (req),
		.cfg      (cfg),
		.valid    (front_valid),
		.left     (left_in),
		.right    (right_in)
	);

	dtffv_wheel u_left (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (front_valid),
		.wheel            (left_in),
		.inv_wheel_radius (cfg.inv_wheel_radius),
		.valid            (left_valid),
		.result           (left_out)
	);

	dtffv_wheel u_right (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (front_valid),
		.wheel            (right_in),
		.inv_wheel_radius (cfg.inv_wheel_radius),
		.valid            (right_valid),
		.result           (right_out)
	);

	assign done = left_valid;
	assign result.left_voltage = left_out.voltage;
	assign result.right_voltage = right_out.voltage;
	assign result.saturated = left_out.ovf | right_out.ovf;

	a_wheels_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		left_valid == right_valid)
		else $error("wheel pipes out of step");

	a_done_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##6 done)
		else $error("accepted transaction gave no result");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 6))
		else $error("result without an accepted transaction");

endmodule
